// ===== hw/rtl/ray_box_slab_intersect_macros.svh =====
// ----------------------------------------------------------------------------
// ray box slab intersect assertion macros
// shared concurrent assertion forms, clocked on aclk, off during reset
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_INTERSECT_MACROS_SVH
`define RAY_BOX_SLAB_INTERSECT_MACROS_SVH

// same-cycle implication
`define RBSI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rbsi assertion failed");

// next-cycle implication
`define RBSI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("rbsi assertion failed");

`endif

// ===== hw/rtl/rbsi_pkg.sv =====
// ----------------------------------------------------------------------------
// rbsi_pkg
// shared types, constants and helpers of the ray box slab intersect block
// ----------------------------------------------------------------------------
package rbsi_pkg;

    localparam int AXES      = 3;
    localparam int DIV_STEPS = 32;
    // init stage, one stage per quotient bit, saturating output stage
    localparam int DIV_LAT   = DIV_STEPS + 2;

    localparam logic [7:0] REG_HALF_SIZE = 8'd0;
    localparam logic [7:0] REG_EPSILON   = 8'd1;

    localparam logic [30:0] HALF_SIZE_RST = 31'd32768;
    localparam logic [15:0] EPSILON_RST   = 16'd7;

    localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    // divider operand: numerator magnitude in units of 2^-16, divisor magnitude
    typedef struct packed {
        logic [32:0] mag;
        logic [31:0] den;
        logic        neg;
    } div_op_t;

    // per item side data carried alongside the dividers
    typedef struct packed {
        logic                  valid;
        logic [AXES-1:0][31:0] org;
        logic [AXES-1:0][31:0] dir;
        logic [AXES-1:0]       par;
        logic [AXES-1:0]       ins;
    } side_t;

    function automatic logic [31:0] sat32(input logic signed [49:0] v);
        logic [31:0] r;
        if (v > $signed({18'd0, Q_MAX})) begin
            r = Q_MAX;
        end else if (v < $signed({{18{1'b1}}, Q_MIN})) begin
            r = Q_MIN;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/rbsi_div_pipe.sv =====
// ----------------------------------------------------------------------------
// rbsi_div_pipe
// pipelined restoring divider, one quotient bit per stage, saturating q16.16
// ----------------------------------------------------------------------------
module rbsi_div_pipe import rbsi_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  div_op_t     op,
    output logic [31:0] quo
);

    logic [31:0] rem_reg [0:DIV_STEPS];
    logic [31:0] q_reg   [0:DIV_STEPS];
    logic [31:0] den_reg [0:DIV_STEPS];
    logic [15:0] lo_reg  [0:DIV_STEPS];
    logic        sat_reg [0:DIV_STEPS];
    logic        neg_reg [0:DIV_STEPS];
    logic [31:0] quo_reg;

    // quotient of 2^32 or more saturates anyway, so start from the top 17 bits
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= {15'd0, op.mag[32:16]};
            q_reg[0]   <= '0;
            den_reg[0] <= op.den;
            lo_reg[0]  <= op.mag[15:0];
            sat_reg[0] <= {15'd0, op.mag[32:16]} >= op.den;
            neg_reg[0] <= op.neg;
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic        nbit;
        logic [32:0] trial;
        logic        take;
        assign nbit  = (k < 16) ? lo_reg[k][15 - (k % 16)] : 1'b0;
        assign trial = {rem_reg[k], nbit};
        assign take  = trial >= {1'b0, den_reg[k]};
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1] <= take ? 32'(trial - {1'b0, den_reg[k]}) : trial[31:0];
                q_reg[k+1]   <= {q_reg[k][30:0], take};
                den_reg[k+1] <= den_reg[k];
                lo_reg[k+1]  <= lo_reg[k];
                sat_reg[k+1] <= sat_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (!neg_reg[DIV_STEPS]) begin
                quo_reg <= (sat_reg[DIV_STEPS] || q_reg[DIV_STEPS][31]) ? Q_MAX
                                                                         : q_reg[DIV_STEPS];
            end else if (sat_reg[DIV_STEPS] || q_reg[DIV_STEPS] > Q_MIN) begin
                quo_reg <= Q_MIN;
            end else begin
                quo_reg <= 32'(-q_reg[DIV_STEPS]);
            end
        end
    end

    assign quo = quo_reg;

endmodule

// ===== hw/rtl/ray_box_slab_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// slab test of a q16.16 ray against an origin-centred cube
// ----------------------------------------------------------------------------
// Takes one ray item per clock and returns one result item per ray, in order.
// An accepted ray passes the input register, the six pipelined 49/32 bit
// slab dividers (one quotient bit per stage), then the ordering, fold, miss,
// hit point and output registers. The whole pipeline advances together: it
// halts only while a result waits at the output and m_ready is low, so with
// m_ready held high one ray enters and one result leaves every cycle.
// half_size and epsilon are written through the cfg port (index 0 and 1,
// other indices ignored) and should change only while no ray is in flight.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect import rbsi_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // ray items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic signed [31:0] s_origin_x,
    input  logic signed [31:0] s_origin_y,
    input  logic signed [31:0] s_origin_z,
    input  logic signed [31:0] s_direction_x,
    input  logic signed [31:0] s_direction_y,
    input  logic signed [31:0] s_direction_z,
    // result items
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_hit,
    output logic signed [31:0] m_distance,
    output logic signed [31:0] m_point_x,
    output logic signed [31:0] m_point_y,
    output logic signed [31:0] m_point_z,
    output logic signed [31:0] m_normal_x,
    output logic signed [31:0] m_normal_y,
    output logic signed [31:0] m_normal_z
);

    `include "ray_box_slab_intersect_macros.svh"

    // configuration registers
    logic [30:0] half_size_reg;
    logic [15:0] epsilon_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_size_reg <= HALF_SIZE_RST;
            epsilon_reg   <= EPSILON_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_HALF_SIZE: half_size_reg <= cfg_data[30:0];
                REG_EPSILON:   epsilon_reg   <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // widened config values for the slab numerators and the inside, ordering, miss and face compares
    logic signed [33:0] hx, ex;
    assign hx = {3'd0, half_size_reg};
    assign ex = {18'd0, epsilon_reg};

    // whole pipeline moves as one, halts only with a result waiting
    logic en;
    assign en      = m_ready || !m_valid;
    assign s_ready = en;

    // ---------------- input register ----------------
    logic                  in_valid_reg;
    logic [AXES-1:0][31:0] in_org_reg, in_dir_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_org_reg <= {s_origin_z, s_origin_y, s_origin_x};
            in_dir_reg <= {s_direction_z, s_direction_y, s_direction_x};
        end
    end

    // ---------------- slab set-up: numerators, divisor, parallel test ----------------
    div_op_t div_a [AXES];
    div_op_t div_b [AXES];
    side_t   side_in;

    always_comb begin
        logic signed [33:0] ox, na, nb;
        logic [32:0]        dm;
        side_in.valid = in_valid_reg;
        side_in.org   = in_org_reg;
        side_in.dir   = in_dir_reg;
        for (int i = 0; i < AXES; i++) begin
            ox = {{2{in_org_reg[i][31]}}, in_org_reg[i]};
            na = -hx - ox;
            nb = hx - ox;
            dm = in_dir_reg[i][31] ? 33'(-{1'b1, in_dir_reg[i]}) : {1'b0, in_dir_reg[i]};
            // near-zero direction: only check the origin lies in the slab
            side_in.par[i] = (in_dir_reg[i] == '0) || (dm < {17'd0, epsilon_reg});
            side_in.ins[i] = !((ox < -hx + ex) || (ox > hx + ex));
            div_a[i].mag = na[33] ? 33'(-na) : na[32:0];
            div_a[i].den = dm[31:0];
            div_a[i].neg = na[33] ^ in_dir_reg[i][31];
            div_b[i].mag = nb[33] ? 33'(-nb) : nb[32:0];
            div_b[i].den = dm[31:0];
            div_b[i].neg = nb[33] ^ in_dir_reg[i][31];
        end
    end

    // ---------------- entry and exit distances ----------------
    logic [31:0] t1_q [AXES];
    logic [31:0] t2_q [AXES];

    for (genvar i = 0; i < AXES; i++) begin : g_axis
        rbsi_div_pipe u_div_entry (.aclk(aclk), .en(en), .op(div_a[i]), .quo(t1_q[i]));
        rbsi_div_pipe u_div_exit  (.aclk(aclk), .en(en), .op(div_b[i]), .quo(t2_q[i]));
    end

    // side data delay line matching the divider latency
    side_t side_reg [DIV_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DIV_LAT; k++) side_reg[k].valid <= 1'b0;
        end else if (en) begin
            side_reg[0] <= side_in;
            for (int k = 1; k < DIV_LAT; k++) side_reg[k] <= side_reg[k-1];
        end
    end

    side_t sd;
    assign sd = side_reg[DIV_LAT-1];

    // ---------------- order each slab pair ----------------
    logic                  p1_valid_reg, p1_bad_reg;
    logic [AXES-1:0][31:0] p1_lo_reg, p1_hi_reg, p1_org_reg, p1_dir_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= sd.valid;
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [33:0] a, b;
        if (en) begin
            p1_bad_reg <= |(sd.par & ~sd.ins);
            p1_org_reg <= sd.org;
            p1_dir_reg <= sd.dir;
            for (int i = 0; i < AXES; i++) begin
                a = {{2{t1_q[i][31]}}, t1_q[i]};
                b = {{2{t2_q[i][31]}}, t2_q[i]};
                if (sd.par[i]) begin
                    // parallel axis leaves near and far untouched
                    p1_lo_reg[i] <= Q_MIN;
                    p1_hi_reg[i] <= Q_MAX;
                end else if (a > b + ex) begin
                    p1_lo_reg[i] <= t2_q[i];
                    p1_hi_reg[i] <= t1_q[i];
                end else begin
                    p1_lo_reg[i] <= t1_q[i];
                    p1_hi_reg[i] <= t2_q[i];
                end
            end
        end
    end

    // ---------------- fold into near and far ----------------
    logic                  p2_valid_reg, p2_bad_reg;
    logic signed [31:0]    p2_near_reg, p2_far_reg;
    logic [AXES-1:0][31:0] p2_org_reg, p2_dir_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (en) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [31:0] nr, fr;
        if (en) begin
            nr = $signed(p1_lo_reg[0]);
            fr = $signed(p1_hi_reg[0]);
            for (int i = 1; i < AXES; i++) begin
                if ($signed(p1_lo_reg[i]) > nr) nr = $signed(p1_lo_reg[i]);
                if ($signed(p1_hi_reg[i]) < fr) fr = $signed(p1_hi_reg[i]);
            end
            p2_near_reg <= nr;
            p2_far_reg  <= fr;
            p2_bad_reg  <= p1_bad_reg;
            p2_org_reg  <= p1_org_reg;
            p2_dir_reg  <= p1_dir_reg;
        end
    end

    // ---------------- miss decision and near t times direction ----------------
    logic                  p3_valid_reg, p3_miss_reg;
    logic signed [31:0]    p3_near_reg;
    logic signed [63:0]    p3_prod_reg [AXES];
    logic [AXES-1:0][31:0] p3_org_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p3_valid_reg <= 1'b0;
        end else if (en) begin
            p3_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [33:0] nx, fx;
        if (en) begin
            nx = {{2{p2_near_reg[31]}}, p2_near_reg};
            fx = {{2{p2_far_reg[31]}}, p2_far_reg};
            p3_miss_reg <= p2_bad_reg || (nx > fx + ex) || (fx < ex);
            p3_near_reg <= p2_near_reg;
            p3_org_reg  <= p2_org_reg;
            for (int i = 0; i < AXES; i++) begin
                p3_prod_reg[i] <= p2_near_reg * $signed(p2_dir_reg[i]);
            end
        end
    end

    // ---------------- hit point ----------------
    logic                  p4_valid_reg, p4_miss_reg;
    logic signed [31:0]    p4_near_reg;
    logic [AXES-1:0][31:0] p4_pt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p4_valid_reg <= 1'b0;
        end else if (en) begin
            p4_valid_reg <= p3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        logic signed [49:0] sum;
        if (en) begin
            p4_miss_reg <= p3_miss_reg;
            p4_near_reg <= p3_near_reg;
            for (int i = 0; i < AXES; i++) begin
                // floor of the q32.32 product back to q16.16
                sum = {{18{p3_org_reg[i][31]}}, p3_org_reg[i]}
                    + {{2{p3_prod_reg[i][63]}}, p3_prod_reg[i][63:16]};
                p4_pt_reg[i] <= sat32(sum);
            end
        end
    end

    // ---------------- face pick and output register ----------------
    logic                  out_valid_reg, out_hit_reg;
    logic [31:0]           out_dist_reg;
    logic [AXES-1:0][31:0] out_pt_reg, out_nrm_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= p4_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        logic [32:0]        ap;
        logic signed [33:0] df;
        logic               found;
        if (en) begin
            found = 1'b0;
            out_hit_reg <= !p4_miss_reg;
            if (p4_miss_reg) begin
                out_dist_reg <= '1;
                out_pt_reg   <= '0;
                out_nrm_reg  <= '0;
            end else begin
                out_dist_reg <= p4_near_reg;
                out_pt_reg   <= p4_pt_reg;
                for (int i = 0; i < AXES; i++) begin
                    ap = p4_pt_reg[i][31] ? 33'(-{1'b1, p4_pt_reg[i]}) : {1'b0, p4_pt_reg[i]};
                    df = {1'b0, ap} - hx;
                    if (df[33]) df = -df;
                    // first axis, x before y before z, whose coordinate sits on a face
                    if (!found && df < ex) begin
                        out_nrm_reg[i] <= p4_pt_reg[i];
                        found = 1'b1;
                    end else begin
                        out_nrm_reg[i] <= '0;
                    end
                end
            end
        end
    end

    assign m_valid    = out_valid_reg;
    assign m_hit      = out_hit_reg;
    assign m_distance = out_dist_reg;
    assign m_point_x  = out_pt_reg[0];
    assign m_point_y  = out_pt_reg[1];
    assign m_point_z  = out_pt_reg[2];
    assign m_normal_x = out_nrm_reg[0];
    assign m_normal_y = out_nrm_reg[1];
    assign m_normal_z = out_nrm_reg[2];

    // ---------------- checks ----------------
    `RBSI_ASSERT_NOW(a_miss_payload, m_valid && !m_hit,
        m_distance == -32'sd1 && m_point_x == 0 && m_point_y == 0 && m_point_z == 0)
    `RBSI_ASSERT_NOW(a_one_face, m_valid && m_hit && m_normal_x != 0,
        m_normal_y == 0 && m_normal_z == 0)
    `RBSI_ASSERT_NEXT(a_stall_holds, m_valid && !m_ready,
        m_valid && $stable(m_distance) && $stable(p4_valid_reg))
endmodule

// ===== sim/rbsi_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rbsi_checker
// watches the ray and result channels, predicts each result item from the
// accepted ray and the current register values, and compares in order
// ----------------------------------------------------------------------------
module rbsi_checker import rbsi_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic signed [31:0] s_origin_x,
    input  logic signed [31:0] s_origin_y,
    input  logic signed [31:0] s_origin_z,
    input  logic signed [31:0] s_direction_x,
    input  logic signed [31:0] s_direction_y,
    input  logic signed [31:0] s_direction_z,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic        m_hit,
    input  logic signed [31:0] m_distance,
    input  logic signed [31:0] m_point_x,
    input  logic signed [31:0] m_point_y,
    input  logic signed [31:0] m_point_z,
    input  logic signed [31:0] m_normal_x,
    input  logic signed [31:0] m_normal_y,
    input  logic signed [31:0] m_normal_z,
    output int          fail_count,
    output int          pending,
    output int          hit_count,
    output int          miss_count
);

    typedef struct packed {
        logic        hit;
        logic [31:0] near_t;
        logic [2:0][31:0] pt;
        logic [2:0][31:0] nrm;
    } hit_rec_t;

    // expected items in flight, more slots than the pipeline holds
    localparam int EXP_DEPTH = 64;

    hit_rec_t    exp_mem [EXP_DEPTH];
    logic [5:0]  wr_idx, rd_idx;
    int          held;
    logic [30:0] cube_half;
    logic [15:0] tol;

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic hit_rec_t trace_box(logic [2:0][31:0] org, logic [2:0][31:0] dir);
        hit_rec_t r;
        longint   o[3], d[3], p, ap, df, t1, t2, tmp, h, e, nr, fr;
        bit       ok, found;
        h = longint'(cube_half);
        e = longint'(tol);
        nr = -64'sd2147483648;
        fr = 64'sd2147483647;
        ok = 1;
        found = 0;
        for (int i = 0; i < 3; i++) begin
            o[i] = longint'($signed(org[i]));
            d[i] = longint'($signed(dir[i]));
        end
        for (int i = 0; i < 3 && ok; i++) begin
            if (d[i] == 0 || (d[i] < 0 ? -d[i] : d[i]) < e) begin
                ok = !(o[i] < -h + e || o[i] > h + e);
            end else begin
                // integer division truncates toward zero, as wanted
                t1 = clamp32(((-h - o[i]) * 65536) / d[i]);
                t2 = clamp32(((h - o[i]) * 65536) / d[i]);
                if (t1 > t2 + e) begin
                    tmp = t1; t1 = t2; t2 = tmp;
                end
                if (t1 > nr) nr = t1;
                if (t2 < fr) fr = t2;
                ok = !(nr > fr + e || fr < e);
            end
        end
        r = '0;
        if (!ok) begin
            r.near_t = '1;
            return r;
        end
        r.hit = 1;
        r.near_t = nr[31:0];
        for (int i = 0; i < 3; i++) begin
            p = clamp32(o[i] + ((nr * d[i]) >>> 16));
            r.pt[i] = p[31:0];
            ap = p < 0 ? -p : p;
            df = ap - h;
            if (df < 0) df = -df;
            if (!found && df < e) begin
                r.nrm[i] = p[31:0];
                found = 1;
            end
        end
        return r;
    endfunction

    assign pending = held;

    always_ff @(posedge aclk) begin
        hit_rec_t exp_r, got;
        int       n_in, n_out;
        if (!aresetn) begin
            cube_half  <= HALF_SIZE_RST;
            tol        <= EPSILON_RST;
            fail_count <= 0;
            hit_count  <= 0;
            miss_count <= 0;
            wr_idx     <= '0;
            rd_idx     <= '0;
            held       <= 0;
        end else begin
            n_in  = 0;
            n_out = 0;
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_HALF_SIZE) cube_half <= cfg_data[30:0];
                else if (cfg_index == REG_EPSILON) tol <= cfg_data[15:0];
            end
            if (s_valid && s_ready) begin
                exp_mem[wr_idx] <= trace_box({s_origin_z, s_origin_y, s_origin_x},
                    {s_direction_z, s_direction_y, s_direction_x});
                wr_idx <= wr_idx + 6'd1;
                n_in = 1;
            end
            if (m_valid && m_ready) begin
                got = {m_hit, m_distance, {m_point_z, m_point_y, m_point_x},
                       {m_normal_z, m_normal_y, m_normal_x}};
                if (held == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10) $display("unexpected result item %h", got);
                end else begin
                    exp_r = exp_mem[rd_idx];
                    rd_idx <= rd_idx + 6'd1;
                    n_out = 1;
                    if (exp_r.hit) hit_count <= hit_count + 1;
                    else miss_count <= miss_count + 1;
                    if (got !== exp_r) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: hit %b/%b dist %h/%h pt %h/%h nrm %h/%h",
                                exp_r.hit, got.hit, exp_r.near_t, got.near_t,
                                exp_r.pt, got.pt, exp_r.nrm, got.nrm);
                    end
                end
            end
            held <= held + n_in - n_out;
        end
    end

endmodule

// ===== sim/tb_ray_box_slab_intersect.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ray_box_slab_intersect
// drives rays and register writes into the slab intersect block with random
// idling on both channels; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_ray_box_slab_intersect import rbsi_pkg::*; ();

    // register index with no register behind it
    localparam logic [7:0] REG_UNUSED = 8'd5;

    logic        aclk, aresetn;
    logic        cfg_valid, cfg_ready;
    logic [7:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_valid, s_ready;
    logic signed [31:0] s_origin_x, s_origin_y, s_origin_z;
    logic signed [31:0] s_direction_x, s_direction_y, s_direction_z;
    logic        m_valid, m_ready, m_hit;
    logic signed [31:0] m_distance, m_point_x, m_point_y, m_point_z;
    logic signed [31:0] m_normal_x, m_normal_y, m_normal_z;
    int          fail_count, pending, hit_count, miss_count;
    int          cycle_count;
    int          rays_sent;
    bit          calm;  // no idling on either side while set

    ray_box_slab_intersect u_top (.*);
    rbsi_checker u_chk (.*);

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // run guard: even fully stalled rays finish well inside this
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver side, random back pressure
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(99) >= 30);
    end

    task automatic write_reg(logic [7:0] idx, logic [31:0] val);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 0;
        @(posedge aclk);
    endtask

    // hold one ray until accepted; idle gap before it at random
    task automatic send_ray(logic [31:0] ox, oy, oz, dx, dy, dz);
        while (!calm && $urandom_range(99) < 30) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_origin_x <= ox; s_origin_y <= oy; s_origin_z <= oz;
        s_direction_x <= dx; s_direction_y <= dy; s_direction_z <= dz;
        do @(posedge aclk); while (!s_ready);
        rays_sent++;
    endtask

    // wait until every result is back, then let the pipeline settle
    task automatic drain();
        s_valid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    // random value near the cube scale, sometimes full range
    function automatic logic [31:0] coord(logic [30:0] h);
        int k;
        k = $urandom_range(9);
        if (k == 0) return $urandom;
        if (k == 1) return {$urandom_range(1) ? -$signed({1'b0, h}) : $signed({1'b0, h})};
        return $signed($urandom_range(2 * h + 2) ) - $signed({1'b0, h}) * 2 / 2 - 1;
    endfunction

    function automatic logic [31:0] heading();
        int k;
        k = $urandom_range(9);
        if (k == 0) return 0;
        if (k == 1) return $signed($urandom_range(20)) - 10;   // near parallel
        if (k == 2) return $urandom;
        return $signed($urandom_range(262144)) - 131072;
    endfunction

    // aimed ray: origin spread to three times the cube scale, direction mostly pointing roughly at the cube
    task automatic aimed_ray(logic [30:0] h);
        logic [31:0] o[3], d[3];
        for (int i = 0; i < 3; i++) begin
            o[i] = coord(h) * 3;
            d[i] = $urandom_range(3) == 0 ? heading()
                 : -($signed(o[i]) >>> 2) + $signed($urandom_range(2000)) - 1000;
        end
        send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    endtask

    initial begin
        logic [30:0] sizes[5];
        logic [31:0] tols[5];
        calm = 0;
        cycle_count = 0;
        rays_sent = 0;
        aresetn = 0;
        cfg_valid = 0; cfg_index = 0; cfg_data = 0;
        s_valid = 0;
        s_origin_x = 0; s_origin_y = 0; s_origin_z = 0;
        s_direction_x = 0; s_direction_y = 0; s_direction_z = 0;
        m_ready = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed rays at reset settings: axis hits, misses, parallel cases
        send_ray(32'hfffe0000, 0, 0, 32'h00010000, 0, 0);
        send_ray(32'h00020000, 0, 0, 32'h00010000, 0, 0);
        send_ray(0, 0, 0, 0, 0, 0);
        send_ray(32'h00010000, 0, 0, 0, 0, 0);
        send_ray(32'h00008003, 0, 0, 3, 0, 0);
        send_ray(32'hfffe0000, 32'hfffe0000, 32'hfffe0000,
                 32'h00010000, 32'h00010000, 32'h00010000);
        send_ray(32'h80000000, 32'h7fffffff, 0, 32'h7fffffff, 32'h80000000, 1);
        send_ray(32'h80000000, 0, 0, 1, 0, 0);
        send_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                 32'h80000000, 32'h80000000, 32'h80000000);
        send_ray(32'h00004000, 32'hfffe0000, 0, 0, 32'h00010000, 7);
        send_ray(32'h00001000, 32'h00001000, 32'hfffe0000, 6, 32'hfffffffa, 32'h00008000);
        send_ray(0, 32'h00030000, 0, 32'h00000100, 32'hffff0000, 0);
        drain();

        // settings sweep, extremes included
        sizes = '{31'd0, 31'h7fffffff, 31'd65536, 31'd32768, 31'd200};
        tols  = '{32'hffff0000, 32'h0000ffff, 32'd0, 32'd7, 32'd3};
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_HALF_SIZE, {1'($urandom_range(1)), sizes[ph]});
            write_reg(REG_EPSILON, tols[ph]);
            write_reg(REG_UNUSED, $urandom);  // ignored by the block
            calm = (ph == 2);
            repeat (370) begin
                if ($urandom_range(99) < 70) aimed_ray(sizes[ph]);
                else send_ray(coord(sizes[ph]), coord(sizes[ph]), coord(sizes[ph]),
                              heading(), heading(), heading());
            end
            drain();
        end
        calm = 0;

        $display("rays sent %0d, hits %0d, misses %0d, five register settings",
                 rays_sent, hit_count, miss_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== ray_box_slab_intersect.f =====
+incdir+hw/rtl
hw/rtl/rbsi_pkg.sv
hw/rtl/rbsi_div_pipe.sv
hw/rtl/ray_box_slab_intersect.sv
sim/rbsi_checker.sv
sim/tb_ray_box_slab_intersect.sv
